### sv/limit_order_matcher_unit_macros.svh
// ----------------------------------------------------------------------------
// Limit order matcher assertion macros
// Clocked assertion forms shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_MATCHER_UNIT_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define LOM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a consequent holds in the same cycle as its antecedent.
`define LOM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/lom_pkg.sv
// ----------------------------------------------------------------------------
// Limit order matcher package
// Types, sizes and codes shared by the matcher modules.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int BookDepth = 32;
  localparam int IdxW      = $clog2(BookDepth);
  localparam int CntW      = $clog2(BookDepth + 1);
  localparam int MaxFills  = 32;
  localparam int FillCntW  = $clog2(MaxFills + 1);

  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  typedef struct packed {
    logic        side;
    logic [9:0]  client;
    logic [7:0]  stock;
    logic [19:0] quantity;
    logic [19:0] limit_price;
  } order_t;

  typedef struct packed {
    logic [31:0] new_order_id;
    logic        matched;
    logic [31:0] resting_order_id;
    logic [9:0]  resting_client;
    logic [19:0] fill_quantity;
    logic [19:0] fill_price;
    logic [19:0] remaining;
    logic        book_full;
    logic        last;
  } result_t;

  // One book entry as held in the memory.
  typedef struct packed {
    logic        side;
    logic [9:0]  client;
    logic [7:0]  stock;
    logic [19:0] quantity;
    logic [19:0] price;
    logic [31:0] ord_seq;
  } entry_t;

endpackage

### sv/lom_book_ram.sv
// ----------------------------------------------------------------------------
// Limit order matcher book memory
// Single port entry store with registered read data.
// ----------------------------------------------------------------------------
module lom_book_ram
  import lom_pkg::*;
(
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] addr_i,
  input  entry_t          wdata_i,
  output entry_t          rdata_o
);

  entry_t mem [BookDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

### sv/limit_order_matcher_unit.sv
// Sequence: for each fill (up to 32) an order runs a scan of the book (depth 32)
// and an update; a scan that finds no match goes straight to the rest phase, as
// does an order of zero quantity. Each fill is then sent after a minimum search
// of the fill buffer. Throughput: one order at a time, the next accepted at the
// first edge with busy low. Reset clears all valid bits and sets the next order
// id to one; the receiver cannot stall, each result is a one-cycle strobe.
// ----------------------------------------------------------------------------
// Limit order matcher unit
// Matches one limit order against a 32 entry book held in a memory.
// ----------------------------------------------------------------------------
module limit_order_matcher_unit
  import lom_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  order_t  order_i,
  output logic    result_valid_o,
  output result_t result_o
);

  // The controller walks these phases. A scan reads every entry through the
  // memory in turn and keeps the best candidate; an update writes the chosen
  // entry back. After matching, the fill list is emitted in id order by
  // repeated minimum searches over the small fill buffer.
  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StScan   = 7'b0000010,
    StUpdate = 7'b0000100,
    StRest   = 7'b0001000,
    StSort   = 7'b0010000,
    StEmit   = 7'b0100000,
    StNone   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [BookDepth-1:0] valid_q;
  logic [31:0]          next_id_q;
  order_t               ord_q;
  logic [31:0]          id_q;
  logic [19:0]          rem_q;
  logic                 full_q;

  // Scan bookkeeping: address issued and whether the read data is live.
  logic [CntW-1:0] scan_q;
  logic            rd_live_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            have_q;
  logic [IdxW-1:0] best_q;
  entry_t          best_e_q;

  // Fill buffer, emitted in ascending resting order id.
  logic [31:0] f_id_q    [MaxFills];
  logic [9:0]  f_cli_q   [MaxFills];
  logic [19:0] f_qty_q   [MaxFills];
  logic [19:0] f_prc_q   [MaxFills];
  logic [MaxFills-1:0] f_done_q;
  logic [FillCntW-1:0] nf_q;
  logic [FillCntW-1:0] emitted_q;
  logic [$clog2(MaxFills)-1:0] sel_q, cur_q;
  logic [FillCntW-1:0] sidx_q;
  logic        scand_q;

  logic            we;
  logic [IdxW-1:0] addr;
  entry_t          wdata, rdata;

  lom_book_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Candidate test on the entry now arriving from memory.
  logic cand, better;
  always_comb begin
    cand = rd_live_q && valid_q[rd_idx_q] && (rdata.side != ord_q.side) &&
           (rdata.stock == ord_q.stock) && (rdata.client != ord_q.client) &&
           ((ord_q.side == SideBuy) ? (rdata.price <= ord_q.limit_price)
                                    : (rdata.price >= ord_q.limit_price));
    if (rdata.price != best_e_q.price) begin
      better = (ord_q.side == SideBuy) ? (rdata.price < best_e_q.price)
                                       : (rdata.price > best_e_q.price);
    end else begin
      better = rdata.ord_seq < best_e_q.ord_seq;
    end
  end

  // Lowest free slot.
  logic            free_any;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = BookDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  logic [19:0] take;
  assign take = (best_e_q.quantity < rem_q) ? best_e_q.quantity : rem_q;

  logic scan_end;
  assign scan_end = (scan_q == CntW'(BookDepth)) && !rd_live_q;

  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    addr    = scan_q[IdxW-1:0];
    wdata   = best_e_q;
    case (state_q)
      StIdle: begin
        if (start) state_d = (order_i.quantity == '0) ? StRest : StScan;
      end
      StScan: begin
        if (scan_end) state_d = have_q ? StUpdate : StRest;
      end
      StUpdate: begin
        we             = 1'b1;
        addr           = best_q;
        wdata.quantity = best_e_q.quantity - take;
        if ((rem_q == take) || (nf_q == FillCntW'(MaxFills - 1))) begin
          state_d = StRest;
        end else begin
          state_d = StScan;
        end
      end
      StRest: begin
        addr           = free_idx;
        wdata.side     = ord_q.side;
        wdata.client   = ord_q.client;
        wdata.stock    = ord_q.stock;
        wdata.quantity = rem_q;
        wdata.price    = ord_q.limit_price;
        wdata.ord_seq  = id_q;
        we             = (rem_q != '0) && free_any;
        state_d        = (nf_q == '0) ? StNone : StSort;
      end
      StSort: begin
        if (sidx_q == FillCntW'(MaxFills)) state_d = StEmit;
      end
      StEmit: begin
        state_d = (emitted_q + 1'b1 == nf_q) ? StIdle : StSort;
      end
      StNone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      valid_q   <= '0;
      next_id_q <= 32'd1;
      f_done_q  <= '0;
      nf_q      <= '0;
      emitted_q <= '0;
      scan_q    <= '0;
      rd_live_q <= 1'b0;
      have_q    <= 1'b0;
      sidx_q    <= '0;
      scand_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          if (start) begin
            ord_q     <= order_i;
            id_q      <= next_id_q;
            next_id_q <= next_id_q + 32'd1;
            rem_q     <= order_i.quantity;
            full_q    <= 1'b0;
            nf_q      <= '0;
            emitted_q <= '0;
            f_done_q  <= '0;
            scan_q    <= '0;
            rd_live_q <= 1'b0;
            have_q    <= 1'b0;
          end
        end
        StScan: begin
          if (scan_q != CntW'(BookDepth)) begin
            rd_idx_q  <= scan_q[IdxW-1:0];
            rd_live_q <= 1'b1;
            scan_q    <= scan_q + 1'b1;
          end else begin
            rd_live_q <= 1'b0;
          end
          // A tie in price and id cannot occur; the lower slot is met first.
          if (cand && (!have_q || better)) begin
            have_q   <= 1'b1;
            best_q   <= rd_idx_q;
            best_e_q <= rdata;
          end
        end
        StUpdate: begin
          f_id_q[nf_q[$clog2(MaxFills)-1:0]]  <= best_e_q.ord_seq;
          f_cli_q[nf_q[$clog2(MaxFills)-1:0]] <= best_e_q.client;
          f_qty_q[nf_q[$clog2(MaxFills)-1:0]] <= take;
          f_prc_q[nf_q[$clog2(MaxFills)-1:0]] <= best_e_q.price;
          nf_q  <= nf_q + 1'b1;
          rem_q <= rem_q - take;
          if (best_e_q.quantity == take) valid_q[best_q] <= 1'b0;
          scan_q    <= '0;
          rd_live_q <= 1'b0;
          have_q    <= 1'b0;
        end
        StRest: begin
          if (rem_q != '0) begin
            if (free_any) valid_q[free_idx] <= 1'b1;
            else full_q <= 1'b1;
          end
          sidx_q  <= '0;
          scand_q <= 1'b0;
        end
        StSort: begin
          // Sequential minimum search over the fills not yet sent.
          if (sidx_q != FillCntW'(MaxFills)) begin
            if ((sidx_q < nf_q) && !f_done_q[sidx_q[$clog2(MaxFills)-1:0]]) begin
              if (!scand_q || (f_id_q[sidx_q[$clog2(MaxFills)-1:0]] < f_id_q[cur_q]))
              begin
                cur_q   <= sidx_q[$clog2(MaxFills)-1:0];
                scand_q <= 1'b1;
              end
            end
            sidx_q <= sidx_q + 1'b1;
          end else begin
            sel_q <= cur_q;
          end
        end
        StEmit: begin
          f_done_q[sel_q] <= 1'b1;
          emitted_q       <= emitted_q + 1'b1;
          sidx_q          <= '0;
          scand_q         <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    result_valid_o = 1'b0;
    result_o       = '0;
    result_o.new_order_id = id_q;
    result_o.remaining    = rem_q;
    result_o.book_full    = full_q;
    if (state_q == StNone) begin
      result_valid_o = 1'b1;
      result_o.last  = 1'b1;
    end else if (state_q == StEmit) begin
      result_valid_o            = 1'b1;
      result_o.matched          = 1'b1;
      result_o.resting_order_id = f_id_q[sel_q];
      result_o.resting_client   = f_cli_q[sel_q];
      result_o.fill_quantity    = f_qty_q[sel_q];
      result_o.fill_price       = f_prc_q[sel_q];
      result_o.last             = (emitted_q + 1'b1 == nf_q);
    end
  end

endmodule

### sv/lom_checker.sv
// ----------------------------------------------------------------------------
// Limit order matcher checker
// Port level properties of the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "limit_order_matcher_unit_macros.svh"
module lom_checker
  import lom_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    result_valid_o,
  input result_t result_o
);

  `LOM_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted order did not raise busy")
  `LOM_ASSERT(a_last_idle, (result_valid_o && result_o.last) |=> !busy, "busy after last")
  `LOM_ASSERT_IMPL(a_res_busy, result_valid_o, busy, "result while idle")
  `LOM_ASSERT_IMPL(a_nomatch, result_valid_o && !result_o.matched, result_o.last, "no-match not last")

endmodule

bind limit_order_matcher_unit lom_checker u_lom_checker (.*);
